// ----- sv/thmhc_pkg.sv -----
// ----------------------------------------------------------------------------
// thmhc_pkg
// shared types, constants and id decode for the tracker module header check
// ----------------------------------------------------------------------------
package thmhc_pkg;

  localparam int OrderTableLenDef = 128;
  localparam int IdOffsetDef      = 1080;

  localparam int PosW     = 11;
  localparam int LenPos   = 950;
  localparam int OrderPos = 952;

  localparam int OutDataW = 80;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SHORT  = 2'd1,
    STATUS_BAD_ID = 2'd2
  } status_t;

  // one input item as held by the input register
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [4:0] channels;
    logic       pc;
  } id_info_t;

  localparam logic [31:0] IdMk   = 32'h4D2E4B2E;
  localparam logic [31:0] IdMkx  = 32'h4D214B21;
  localparam logic [31:0] IdFlt4 = 32'h464C5434;
  localparam logic [31:0] IdFlt8 = 32'h464C5438;
  localparam logic [31:0] IdOkta = 32'h4F4B5441;
  localparam logic [31:0] IdOcta = 32'h4F435441;
  localparam logic [31:0] Id8chn = 32'h3843484E;
  localparam logic [23:0] TailChn = 24'h43484E;
  localparam logic [15:0] TailCh  = 16'h4348;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChNine  = 8'h39;

  function automatic id_info_t decode_id(input logic [31:0] id);
    id_info_t   r;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] t1;
    logic [7:0] t2;
    d1 = id[31:24];
    d2 = id[23:16];
    t1 = d1 - ChZero;
    t2 = d2 - ChZero;
    r  = '0;
    if (id == IdMk || id == IdMkx || id == IdFlt4) begin
      r.channels = 5'd4;
    end else if (id == IdFlt8) begin
      r.channels = 5'd8;
    end else if (id == IdOkta || id == IdOcta || id == Id8chn) begin
      r.channels = 5'd8;
      r.pc       = 1'b1;
    end else if (d1 >= ChOne && d1 < ChNine && id[23:0] == TailChn) begin
      r.channels = t1[4:0];
      r.pc       = 1'b1;
    end else if (d1 >= ChOne && d1 < ChThree && d2 >= ChZero && d2 <= ChNine &&
                 id[15:0] == TailCh) begin
      // tens digit is 1 or 2
      r.channels = 5'(t1[1:0]) * 5'd10 + t2[4:0];
      r.pc       = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- sv/tracker_module_header_check_unit.sv -----
// ----------------------------------------------------------------------------
// tracker_module_header_check_unit
// checks the header of a tracker module file streamed byte by byte
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = byte_last
// m_*      out  m_tvalid/m_tready  m_tdata = result fields, m_tuser = status
//
// one byte per cycle while the result is not stalled; a byte is taken into
// the input register, then its result is loaded into the result register
// rst clears the position, the pattern maximum, id, length and done flag
// a stalled result holds while the input register still takes one byte
// ----------------------------------------------------------------------------
module tracker_module_header_check_unit #(
  parameter int ORDER_TABLE_LEN = thmhc_pkg::OrderTableLenDef,
  parameter int ID_OFFSET       = thmhc_pkg::IdOffsetDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // byte_last
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [4:0] channel_count, [5] mode_pc, [14:6] pattern_count,
  // [22:15] song_length, [54:23] module_id, [76:55] needed_bytes
  output logic [thmhc_pkg::OutDataW-1:0] m_tdata,
  output logic [1:0]                     m_tuser    // [1:0] status
);

  thmhc_pkg::in_item_t item;
  logic                advance;

  thmhc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .item     (item)
  );

  thmhc_parse #(
    .ORDER_TABLE_LEN (ORDER_TABLE_LEN),
    .ID_OFFSET       (ID_OFFSET)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- sv/thmhc_in_stage.sv -----
// ----------------------------------------------------------------------------
// thmhc_in_stage
// input register for the byte stream
// ----------------------------------------------------------------------------
module thmhc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,   // byte_last
  input  logic               advance,
  output thmhc_pkg::in_item_t item
);

  assign s_tready = !item.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tready) begin
      item.valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.data <= s_tdata;
      item.last <= s_tlast;
    end
  end

endmodule

// ----- sv/thmhc_parse.sv -----
// ----------------------------------------------------------------------------
// thmhc_parse
// header state, id decode and result register
// ----------------------------------------------------------------------------
module thmhc_parse #(
  parameter int ORDER_TABLE_LEN = thmhc_pkg::OrderTableLenDef,
  parameter int ID_OFFSET       = thmhc_pkg::IdOffsetDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  thmhc_pkg::in_item_t               item,
  output logic                              advance,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [thmhc_pkg::OutDataW-1:0]    m_tdata,
  output logic [1:0]                        m_tuser
);

  localparam logic [11:0] LenAt     = 12'(thmhc_pkg::LenPos);
  localparam logic [11:0] OrderLo   = 12'(thmhc_pkg::OrderPos);
  localparam logic [11:0] OrderHi   = 12'(thmhc_pkg::OrderPos + ORDER_TABLE_LEN);
  localparam logic [11:0] IdLo      = 12'(ID_OFFSET);
  localparam logic [11:0] IdHi      = 12'(ID_OFFSET + 4);
  localparam logic [11:0] IdLastAt  = 12'(ID_OFFSET + 3);
  localparam logic [21:0] HeaderLen = 22'(ID_OFFSET + 4);
  localparam logic [thmhc_pkg::PosW-1:0] PosMax = '1;

  logic [thmhc_pkg::PosW-1:0] byte_position;
  logic [7:0]                 max_pattern;
  logic [31:0]                id_shift;
  logic [7:0]                 length_byte;
  logic                       done_flag;

  logic [7:0]  max_next;
  logic [31:0] id_next;
  logic [7:0]  len_next;
  logic [11:0] pos_ext;
  logic        take;
  logic        at_id_end;
  logic        fire;

  thmhc_pkg::id_info_t info;
  logic [7:0]  eff_max;
  logic [8:0]  pats;
  logic [13:0] pat_ch;

  logic [1:0]  res_status;
  logic [4:0]  res_ch;
  logic        res_pc;
  logic [8:0]  res_pats;
  logic [21:0] res_need;

  assign advance = !m_tvalid || m_tready;
  assign take    = item.valid && advance;
  assign pos_ext = {1'b0, byte_position};

  always_comb begin
    len_next = (pos_ext == LenAt) ? item.data : length_byte;
    max_next = max_pattern;
    if (pos_ext >= OrderLo && pos_ext < OrderHi && item.data > max_pattern) begin
      max_next = item.data;
    end
    id_next = id_shift;
    if (pos_ext >= IdLo && pos_ext < IdHi) begin
      id_next = {id_shift[23:0], item.data};
    end
  end

  assign at_id_end = (pos_ext == IdLastAt);
  assign fire      = take && !done_flag && (at_id_end || item.last);

  // result fields and status for a short stream, an unknown id or a known id
  always_comb begin
    info     = thmhc_pkg::decode_id(id_next);
    eff_max  = (id_next == thmhc_pkg::IdFlt8) ? {1'b0, max_next[7:1]} : max_next;
    pats     = {1'b0, eff_max} + 9'd1;
    pat_ch   = pats * info.channels;
    if (!at_id_end) begin
      res_status = thmhc_pkg::STATUS_SHORT;
      res_ch     = '0;
      res_pc     = 1'b0;
      res_pats   = '0;
      res_need   = '0;
    end else if (info.channels == 5'd0) begin
      res_status = thmhc_pkg::STATUS_BAD_ID;
      res_ch     = '0;
      res_pc     = 1'b0;
      res_pats   = '0;
      res_need   = '0;
    end else begin
      res_status = thmhc_pkg::STATUS_OK;
      res_ch     = info.channels;
      res_pc     = info.pc;
      res_pats   = pats;
      // 64 rows of 4 bytes per channel
      res_need   = {pat_ch, 8'd0} + HeaderLen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      max_pattern   <= '0;
      id_shift      <= '0;
      length_byte   <= '0;
      done_flag     <= 1'b0;
    end else if (take) begin
      if (item.last) begin
        byte_position <= '0;
        max_pattern   <= '0;
        id_shift      <= '0;
        length_byte   <= '0;
        done_flag     <= 1'b0;
      end else if (!done_flag) begin
        max_pattern <= max_next;
        id_shift    <= id_next;
        length_byte <= len_next;
        if (at_id_end) begin
          done_flag <= 1'b1;
        end else if (byte_position != PosMax) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      m_tuser <= res_status;
      m_tdata <= {3'd0, res_need,
                  (at_id_end ? id_next : 32'd0),
                  (at_id_end ? len_next : 8'd0),
                  res_pats, res_pc, res_ch};
    end
  end

endmodule

// ----- tb/sv/tracker_module_header_check_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_module_header_check_unit_test
// streams module files into the header check and compares every result
// against a cycle-free prediction of position, order table maximum and id
// decode; covers every id rule, short streams, trailing bytes and random
// files under sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tracker_module_header_check_unit_test;

  localparam int IdLastPos  = thmhc_pkg::IdOffsetDef + 3;
  localparam int OrderEnd   = thmhc_pkg::OrderPos + thmhc_pkg::OrderTableLenDef;
  localparam int CycleLimit = 2000000;
  localparam logic [7:0] AsciiZero = "0";

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN
  } rdy_mode_t;

  typedef struct packed {
    thmhc_pkg::status_t status;
    logic [4:0]         channels;
    logic               pc;
    logic [8:0]         patterns;
    logic [7:0]         song;
    logic [31:0]        id;
    logic [21:0]        needed;
  } header_result_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata  = 8'h00;
  logic                           s_tlast  = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [thmhc_pkg::OutDataW-1:0] m_tdata;
  logic [1:0]                     m_tuser;

  // predicted block state
  logic [10:0] trk_pos;
  logic [7:0]  trk_max_pat;
  logic [31:0] trk_id;
  logic [7:0]  trk_song;
  logic        trk_done;

  header_result_t pending_headers[$];

  int        fail_cnt    = 0;
  int        cycle_cnt   = 0;
  int        byte_cnt    = 0;
  int        stream_cnt  = 0;
  int        checked_cnt = 0;
  int        burst_left  = 0;
  bit        idle_on     = 1'b0;
  rdy_mode_t rdy_mode    = RDY_ALWAYS;

  tracker_module_header_check_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tracker_module_header_check_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (rdy_mode)
      RDY_ALWAYS: m_tready <= 1'b1;
      RDY_RANDOM: m_tready <= ($urandom_range(0, 9) < 6);
      default:    m_tready <= (cycle_cnt % 11) >= 4;
    endcase
  end

  function automatic void clear_tracker();
    trk_pos     = '0;
    trk_max_pat = '0;
    trk_id      = '0;
    trk_song    = '0;
    trk_done    = 1'b0;
  endfunction

  // returns {pc, channels}, zero for an unknown id
  function automatic logic [5:0] decode_format(input logic [31:0] id);
    logic [7:0] hi;
    logic [7:0] nx;
    hi = id[31:24];
    nx = id[23:16];
    if (id == "M.K." || id == "M!K!" || id == "FLT4") return {1'b0, 5'd4};
    if (id == "FLT8") return {1'b0, 5'd8};
    if (id == "OKTA" || id == "OCTA" || id == "8CHN") return {1'b1, 5'd8};
    if (hi >= "1" && hi <= "8" && id[23:0] == "CHN") return {1'b1, 5'(hi - AsciiZero)};
    if (hi >= "1" && hi <= "2" && nx >= "0" && nx <= "9" && id[15:0] == "CH")
      return {1'b1, 5'((hi - AsciiZero) * 10 + (nx - AsciiZero))};
    return 6'd0;
  endfunction

  // advance the predicted header state by one accepted item
  function automatic void track_header_byte(input logic [7:0] b, input logic last);
    header_result_t r;
    logic [5:0]     fmt;
    int             top;
    int             pats;
    if (trk_done) begin
      if (last) clear_tracker();
      return;
    end
    if (trk_pos == thmhc_pkg::LenPos) trk_song = b;
    if (trk_pos >= thmhc_pkg::OrderPos && trk_pos < OrderEnd && b > trk_max_pat)
      trk_max_pat = b;
    if (trk_pos >= thmhc_pkg::IdOffsetDef && trk_pos <= IdLastPos)
      trk_id = {trk_id[23:0], b};
    r = '0;
    if (trk_pos == IdLastPos) begin
      fmt     = decode_format(trk_id);
      r.song  = trk_song;
      r.id    = trk_id;
      if (fmt[4:0] == 5'd0) begin
        r.status = thmhc_pkg::STATUS_BAD_ID;
      end else begin
        // eight-channel classic id stores pattern pairs
        top        = (trk_id == "FLT8") ? (trk_max_pat >> 1) : trk_max_pat;
        pats       = top + 1;
        r.status   = thmhc_pkg::STATUS_OK;
        r.channels = fmt[4:0];
        r.pc       = fmt[5];
        r.patterns = 9'(pats);
        r.needed   = 22'(pats * int'(fmt[4:0]) * 256 + thmhc_pkg::IdOffsetDef + 4);
      end
      pending_headers.push_back(r);
      if (last) clear_tracker();
      else trk_done = 1'b1;
      return;
    end
    if (last) begin
      r.status = thmhc_pkg::STATUS_SHORT;
      pending_headers.push_back(r);
      clear_tracker();
      return;
    end
    if (trk_pos != 11'h7FF) trk_pos = trk_pos + 11'd1;
  endfunction

  always @(posedge clk) begin : check_results
    header_result_t exp_r;
    header_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status   = thmhc_pkg::status_t'(m_tuser);
      got.channels = m_tdata[4:0];
      got.pc       = m_tdata[5];
      got.patterns = m_tdata[14:6];
      got.song     = m_tdata[22:15];
      got.id       = m_tdata[54:23];
      got.needed   = m_tdata[76:55];
      if (pending_headers.size() == 0) begin
        $error("unexpected result: status %0d id %08h", got.status, got.id);
        fail_cnt++;
      end else begin
        exp_r = pending_headers.pop_front();
        checked_cnt++;
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d got %0d", exp_r.status, got.status);
          fail_cnt++;
        end
        if (got.channels !== exp_r.channels) begin
          $error("channel_count: expected %0d got %0d", exp_r.channels, got.channels);
          fail_cnt++;
        end
        if (got.pc !== exp_r.pc) begin
          $error("mode_pc: expected %0d got %0d", exp_r.pc, got.pc);
          fail_cnt++;
        end
        if (got.patterns !== exp_r.patterns) begin
          $error("pattern_count: expected %0d got %0d", exp_r.patterns, got.patterns);
          fail_cnt++;
        end
        if (got.song !== exp_r.song) begin
          $error("song_length: expected %0d got %0d", exp_r.song, got.song);
          fail_cnt++;
        end
        if (got.id !== exp_r.id) begin
          $error("module_id: expected %08h got %08h", exp_r.id, got.id);
          fail_cnt++;
        end
        if (got.needed !== exp_r.needed) begin
          $error("needed_bytes: expected %0d got %0d", exp_r.needed, got.needed);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    track_header_byte(b, last);
    byte_cnt++;
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_headers.size() != 0) @(posedge clk);
  endtask

  // full header; tail bytes follow the id, last mark on the final byte
  task automatic send_file(input logic [31:0] id, input logic [7:0] top_pat,
                           input logic [7:0] song, input int tail);
    int         peak_at;
    logic [7:0] b;
    peak_at = thmhc_pkg::OrderPos + $urandom_range(0, thmhc_pkg::OrderTableLenDef - 1);
    stream_cnt++;
    for (int p = 0; p < thmhc_pkg::IdOffsetDef + 4 + tail; p++) begin
      if (p == thmhc_pkg::LenPos) b = song;
      else if (p == peak_at) b = top_pat;
      else if (p >= thmhc_pkg::OrderPos && p < OrderEnd) b = 8'($urandom_range(0, top_pat));
      else if (p >= thmhc_pkg::IdOffsetDef && p <= IdLastPos)
        b = id[8 * (IdLastPos - p) +: 8];
      else b = 8'($urandom);
      send_byte(b, p == IdLastPos + tail);
    end
  endtask

  task automatic send_short(input int len);
    stream_cnt++;
    for (int p = 0; p < len; p++) send_byte(8'($urandom), p == len - 1);
  endtask

  task automatic test_short_streams();
    send_short(1);
    send_short(thmhc_pkg::LenPos + 1);
    send_short(IdLastPos);
    wait_results();
  endtask

  task automatic test_known_ids();
    send_file("M.K.", 8'd0, 8'd0, 1);
    send_file("M!K!", 8'd255, 8'd255, 2);
    send_file("FLT4", 8'd31, 8'd40, 1);
    send_file("FLT8", 8'd255, 8'd12, 1);
    send_file("FLT8", 8'd6, 8'd3, 1);
    send_file("OKTA", 8'd9, 8'd70, 1);
    send_file("OCTA", 8'd63, 8'd128, 1);
    send_file("8CHN", 8'd1, 8'd1, 1);
  endtask

  task automatic test_digit_ids();
    send_file("1CHN", 8'd4, 8'd5, 1);
    send_file("5CHN", 8'd20, 8'd9, 1);
    send_file("10CH", 8'd0, 8'd2, 1);
    send_file("19CH", 8'd100, 8'd77, 1);
    send_file("29CH", 8'd255, 8'd255, 1);
  endtask

  task automatic test_unknown_ids();
    send_file("9CHN", 8'd3, 8'd8, 1);
    send_file("0CHN", 8'd3, 8'd8, 1);
    send_file("30CH", 8'd3, 8'd8, 1);
    send_file("1:CH", 8'd3, 8'd8, 1);
    send_file("2/CH", 8'd3, 8'd8, 1);
    send_file(32'h00000000, 8'd3, 8'd8, 1);
    send_file(32'hFFFFFFFF, 8'd3, 8'd8, 1);
  endtask

  task automatic test_trailing_bytes();
    // last mark right on the final id byte, then a long tail
    send_file("M.K.", 8'd12, 8'd20, 0);
    send_file("M.K.", 8'd12, 8'd20, 40);
    wait_results();
  endtask

  function automatic logic [31:0] random_id();
    logic [31:0] known[7] = '{"M.K.", "M!K!", "FLT4", "FLT8", "OKTA", "OCTA", "8CHN"};
    logic [31:0] id;
    case ($urandom_range(0, 5))
      0: id = known[$urandom_range(0, 6)];
      1: id = {8'("0") + 8'($urandom_range(1, 8)), 24'("CHN")};
      2: id = {8'("0") + 8'($urandom_range(1, 2)), 8'("0") + 8'($urandom_range(0, 9)),
               16'("CH")};
      3: begin
        // near miss of a known id
        id = known[$urandom_range(0, 6)];
        id[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
      end
      4: id = $urandom;
      default: id = {8'("0") + 8'($urandom_range(0, 10)), 8'("/") + 8'($urandom_range(0, 11)),
                     ($urandom_range(0, 1) == 0) ? 16'("CH") : 16'("HN")};
    endcase
    return id;
  endfunction

  task automatic test_random_files();
    logic [7:0] top_pat;
    int         tail;
    for (int n = 0; n < 64; n++) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      rdy_mode = rdy_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        send_short(($urandom_range(0, 1) == 0) ? $urandom_range(1, 63)
                                               : $urandom_range(1, IdLastPos));
      end else begin
        case ($urandom_range(0, 3))
          0:       top_pat = 8'($urandom);
          1:       top_pat = 8'd255;
          default: top_pat = 8'($urandom_range(0, 63));
        endcase
        tail = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        send_file(random_id(), top_pat, 8'($urandom), tail);
      end
      if (n % 8 == 7) wait_results();
    end
  endtask

  initial begin
    clear_tracker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on  = 1'b0;
    rdy_mode = RDY_ALWAYS;
    test_short_streams();
    idle_on  = 1'b1;
    rdy_mode = RDY_PATTERN;
    test_known_ids();
    rdy_mode = RDY_RANDOM;
    test_digit_ids();
    test_unknown_ids();
    idle_on  = 1'b0;
    test_trailing_bytes();
    test_random_files();

    wait_results();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d streams; %0d header results checked",
             byte_cnt, stream_cnt, checked_cnt);
    $display("id rules, short streams, trailing bytes, sender gaps and receiver stalls");
    if (fail_cnt == 0) begin
      $display("tracker_module_header_check_unit regression: pass");
    end else begin
      $display("tracker_module_header_check_unit regression: fail");
    end
    $finish;
  end

endmodule
